// File: rtl/srst_pkg.sv
`default_nettype none

package srst_pkg;

  localparam int NUM_VARS  = 256;
  localparam int LOG_DEPTH = 1024;

  localparam int VAR_W  = $clog2(NUM_VARS);
  localparam int LA_W   = $clog2(LOG_DEPTH);
  localparam int FILL_W = $clog2(LOG_DEPTH + 1);

  localparam int BLK_W = 16;
  localparam int VER_W = 16;
  localparam int CNT_W = 11;

  localparam logic [1:0] KIND_USE = 2'd0;
  localparam logic [1:0] KIND_DEF = 2'd1;
  localparam logic [1:0] KIND_POP = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_DEF   = 2'd1;
  localparam logic [1:0] ST_LOG_FULL = 2'd2;

  typedef enum logic [1:0] {
    OP_USE,
    OP_DEF,
    OP_POP,
    OP_NOP
  } op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_POP_CHK,
    S_FINISH
  } state_t;

  typedef struct packed {
    op_t              op;
    logic [VAR_W-1:0] var_index;
    logic [BLK_W-1:0] block_id;
    logic [VER_W-1:0] version;
  } cmd_t;

  typedef struct packed {
    logic [BLK_W-1:0] block;
    logic [VER_W-1:0] version;
  } top_t;

  typedef struct packed {
    logic [VAR_W-1:0] var_index;
    logic [BLK_W-1:0] block;
    logic             prev_valid;
    top_t             prev;
  } log_t;

endpackage

`default_nettype wire

// File: rtl/srst_front.sv
`default_nettype none

module srst_front (
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic [1:0]              kind,
  input  wire logic [7:0]              var_index,
  input  wire logic [15:0]             block_id,
  input  wire logic [15:0]             version,
  input  wire logic                    q_full,
  output logic                         q_push,
  output srst_pkg::cmd_t               q_cmd
);

  always_comb begin
    in_stall = q_full;
    q_push   = in_valid && !q_full;

    case (kind)
      srst_pkg::KIND_USE: q_cmd.op = srst_pkg::OP_USE;
      srst_pkg::KIND_DEF: q_cmd.op = srst_pkg::OP_DEF;
      srst_pkg::KIND_POP: q_cmd.op = srst_pkg::OP_POP;
      default:            q_cmd.op = srst_pkg::OP_NOP;
    endcase

    q_cmd.var_index = var_index[srst_pkg::VAR_W-1:0];
    q_cmd.block_id  = block_id;
    q_cmd.version   = version;
  end

endmodule

`default_nettype wire

// File: rtl/srst_queue.sv
`default_nettype none

module srst_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire srst_pkg::cmd_t push_cmd,
  output logic                full,
  output logic                head_valid,
  output srst_pkg::cmd_t      head_cmd,
  input  wire logic           take
);

  srst_pkg::cmd_t entries [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;

  logic do_push;
  logic do_take;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head_cmd   = entries[rd_ptr];
  assign do_push    = push && !full;
  assign do_take    = take && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_take) begin
        rd_ptr <= !rd_ptr;
      end
      case ({do_push, do_take})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

// File: rtl/srst_back.sv
`default_nettype none

module srst_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           q_valid,
  input  wire srst_pkg::cmd_t q_cmd,
  output logic                q_take,
  output logic                out_valid,
  input  wire logic           out_stall,
  output logic [15:0]         top_version,
  output logic [1:0]          status,
  output logic [10:0]         popped
);

  localparam int VAR_W  = srst_pkg::VAR_W;
  localparam int LA_W   = srst_pkg::LA_W;
  localparam int FILL_W = srst_pkg::FILL_W;
  localparam int CNT_W  = srst_pkg::CNT_W;

  // top table: block/version in RAM, valid bits in flops
  srst_pkg::top_t top_mem [srst_pkg::NUM_VARS];
  logic [srst_pkg::NUM_VARS-1:0] top_valid;
  srst_pkg::log_t log_mem [srst_pkg::LOG_DEPTH];

  srst_pkg::state_t state;
  srst_pkg::state_t state_next;

  srst_pkg::cmd_t  cur;
  srst_pkg::top_t  top_q;
  srst_pkg::log_t  log_q;
  logic [FILL_W-1:0] fill;
  logic [CNT_W-1:0]  cnt;

  logic [FILL_W-1:0] fill_m1;
  logic [FILL_W-1:0] fill_m2;
  logic              out_free;
  logic              cur_hit;
  logic              cur_same;
  logic              log_full;
  logic              log_match;

  logic               top_rd_en;
  logic [VAR_W-1:0]   top_rd_addr;
  logic               top_wr_en;
  logic [VAR_W-1:0]   top_wr_addr;
  srst_pkg::top_t     top_wr_data;
  logic               top_wr_valid;
  logic               log_rd_en;
  logic [LA_W-1:0]    log_rd_addr;
  logic               log_wr_en;
  srst_pkg::log_t     log_wr_data;
  logic               fill_inc;
  logic               fill_dec;
  logic               cnt_inc;
  logic               out_load;
  logic [15:0]        res_version;
  logic [1:0]         res_status;
  logic [CNT_W-1:0]   res_popped;

  assign fill_m1   = fill - FILL_W'(1);
  assign fill_m2   = fill - FILL_W'(2);
  assign out_free  = !out_valid || !out_stall;
  assign cur_hit   = top_valid[cur.var_index];
  assign cur_same  = cur_hit && (top_q.block == cur.block_id);
  assign log_full  = (fill == FILL_W'(srst_pkg::LOG_DEPTH));
  assign log_match = (log_q.block == cur.block_id);

  always_comb begin
    state_next = state;
    case (state)
      srst_pkg::S_IDLE: begin
        if (q_valid) begin
          case (q_cmd.op)
            srst_pkg::OP_USE,
            srst_pkg::OP_DEF: state_next = srst_pkg::S_EXEC;
            srst_pkg::OP_POP: begin
              state_next = (fill != '0) ? srst_pkg::S_POP_CHK : srst_pkg::S_FINISH;
            end
            default:          state_next = srst_pkg::S_FINISH;
          endcase
        end
      end
      srst_pkg::S_EXEC: begin
        if (out_free) begin
          state_next = srst_pkg::S_IDLE;
        end
      end
      srst_pkg::S_POP_CHK: begin
        if (!log_match || fill == FILL_W'(1)) begin
          state_next = srst_pkg::S_FINISH;
        end
      end
      srst_pkg::S_FINISH: begin
        if (out_free) begin
          state_next = srst_pkg::S_IDLE;
        end
      end
      default: state_next = srst_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    q_take       = 1'b0;
    top_rd_en    = 1'b0;
    top_rd_addr  = q_cmd.var_index;
    top_wr_en    = 1'b0;
    top_wr_addr  = cur.var_index;
    top_wr_data  = '{block: cur.block_id, version: cur.version};
    top_wr_valid = 1'b1;
    log_rd_en    = 1'b0;
    log_rd_addr  = fill_m1[LA_W-1:0];
    log_wr_en    = 1'b0;
    log_wr_data  = '{var_index: cur.var_index, block: cur.block_id,
                     prev_valid: cur_hit, prev: top_q};
    fill_inc     = 1'b0;
    fill_dec     = 1'b0;
    cnt_inc      = 1'b0;
    out_load     = 1'b0;
    res_version  = '0;
    res_status   = srst_pkg::ST_OK;
    res_popped   = '0;

    case (state)
      srst_pkg::S_IDLE: begin
        if (q_valid) begin
          q_take = 1'b1;
          case (q_cmd.op)
            srst_pkg::OP_USE,
            srst_pkg::OP_DEF: top_rd_en = 1'b1;
            srst_pkg::OP_POP: log_rd_en = (fill != '0);
            default:          top_rd_en = 1'b0;
          endcase
        end
      end
      srst_pkg::S_EXEC: begin
        if (out_free) begin
          out_load = 1'b1;
          if (cur.op == srst_pkg::OP_USE) begin
            res_version = cur_hit ? top_q.version : '0;
            res_status  = cur_hit ? srst_pkg::ST_OK : srst_pkg::ST_NO_DEF;
          end else if (cur_same) begin
            top_wr_en = 1'b1;
          end else if (log_full) begin
            res_status = srst_pkg::ST_LOG_FULL;
          end else begin
            top_wr_en = 1'b1;
            log_wr_en = 1'b1;
            fill_inc  = 1'b1;
          end
        end
      end
      srst_pkg::S_POP_CHK: begin
        if (log_match) begin
          top_wr_en    = 1'b1;
          top_wr_addr  = log_q.var_index;
          top_wr_data  = log_q.prev;
          top_wr_valid = log_q.prev_valid;
          fill_dec     = 1'b1;
          cnt_inc      = 1'b1;
          if (fill != FILL_W'(1)) begin
            log_rd_en   = 1'b1;
            log_rd_addr = fill_m2[LA_W-1:0];
          end
        end
      end
      srst_pkg::S_FINISH: begin
        if (out_free) begin
          out_load   = 1'b1;
          res_popped = cnt;
        end
      end
      default: out_load = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= srst_pkg::S_IDLE;
      top_valid <= '0;
      fill      <= '0;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (top_wr_en) begin
        top_valid[top_wr_addr] <= top_wr_valid;
      end
      if (fill_inc) begin
        fill <= fill + FILL_W'(1);
      end else if (fill_dec) begin
        fill <= fill_m1;
      end
      if (q_take) begin
        cnt <= '0;
      end else if (cnt_inc) begin
        cnt <= cnt + CNT_W'(1);
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_take) begin
      cur <= q_cmd;
    end
    if (out_load) begin
      top_version <= res_version;
      status      <= res_status;
      popped      <= res_popped;
    end
  end

  always_ff @(posedge clk) begin
    if (top_wr_en) begin
      top_mem[top_wr_addr] <= top_wr_data;
    end
    if (top_rd_en) begin
      top_q <= top_mem[top_rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (log_wr_en) begin
      log_mem[fill[LA_W-1:0]] <= log_wr_data;
    end
    if (log_rd_en) begin
      log_q <= log_mem[log_rd_addr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/ssa_rename_stack_table.sv
// SSA rename version stacks: one top-of-stack entry per variable plus a
// shared undo log of covered tops.
// Input channel (in_valid / in_stall): kind, var_index, block_id, version.
// Output channel (out_valid / out_stall): top_version, status, popped; exactly
// one result item per input item, in input order.
// A two-entry queue sits behind the input, so items are taken while the
// execution side is busy; in_stall rises only when that queue is full.
// Use and define: top-table RAM read, then update and result in the execution
// side; the update waits for the registered read of the top table.
// Pop-block: undo-log RAM read, then one unwind step per matching log entry,
// each restoring a top and reading the next entry, then the result.
// Unknown kind: all-zero result.
// Reset clears all top-table valid bits, empties the log, the input queue
// and the result register.
// No clearing pass is needed; the block takes items straight after reset.
// While out_stall is high with a result waiting, the result register holds and
// execution of the next item waits at its result step; the input queue keeps filling.
`default_nettype none

module ssa_rename_stack_table (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  kind,
  input  wire logic [7:0]  var_index,
  input  wire logic [15:0] block_id,
  input  wire logic [15:0] version,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      top_version,
  output logic [1:0]       status,
  output logic [10:0]      popped
);

  logic           q_full;
  logic           q_push;
  srst_pkg::cmd_t q_in_cmd;
  logic           q_valid;
  srst_pkg::cmd_t q_head;
  logic           q_take;

  srst_front u_front (
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .kind      (kind),
    .var_index (var_index),
    .block_id  (block_id),
    .version   (version),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (q_in_cmd)
  );

  srst_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_cmd   (q_in_cmd),
    .full       (q_full),
    .head_valid (q_valid),
    .head_cmd   (q_head),
    .take       (q_take)
  );

  srst_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_cmd       (q_head),
    .q_take      (q_take),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .top_version (top_version),
    .status      (status),
    .popped      (popped)
  );

endmodule

`default_nettype wire

// File: test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  localparam logic [1:0] KIND_BAD = 2'd3;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  vidx;
    logic [15:0] blk;
    logic [15:0] ver;
  } rename_req_t;

  typedef struct packed {
    logic [15:0] top_version;
    logic [1:0]  status;
    logic [10:0] popped;
  } rename_rsp_t;

  typedef struct packed {
    rename_req_t req;
    logic        typed;
    rename_rsp_t want;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  kind = srst_pkg::KIND_USE;
  logic [7:0]  var_index = '0;
  logic [15:0] block_id = '0;
  logic [15:0] version = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] top_version;
  logic [1:0]  status;
  logic [10:0] popped;

  ssa_rename_stack_table dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .kind(kind), .var_index(var_index), .block_id(block_id), .version(version),
    .out_valid(out_valid), .out_stall(out_stall),
    .top_version(top_version), .status(status), .popped(popped)
  );

  always #1 clk = ~clk;

  // shadow of the version stacks
  logic        top_valid [srst_pkg::NUM_VARS];
  logic [15:0] top_blk [srst_pkg::NUM_VARS];
  logic [15:0] top_ver [srst_pkg::NUM_VARS];
  logic [7:0]  undo_var [srst_pkg::LOG_DEPTH];
  logic [15:0] undo_blk [srst_pkg::LOG_DEPTH];
  logic        undo_pvalid [srst_pkg::LOG_DEPTH];
  logic [15:0] undo_pblk [srst_pkg::LOG_DEPTH];
  logic [15:0] undo_pver [srst_pkg::LOG_DEPTH];
  int unsigned undo_fill;

  rename_rsp_t expected_rsp_q [$];
  rename_rsp_t rsp_head;
  int unsigned n_errors;
  int unsigned n_accepted;
  int unsigned burst_left;

  function automatic rename_rsp_t rename_predict(rename_req_t r);
    rename_rsp_t rsp;
    int unsigned n;
    rsp = '0;
    n = 0;
    case (r.kind)
      srst_pkg::KIND_USE: begin
        if (int'(r.vidx) < srst_pkg::NUM_VARS && top_valid[r.vidx])
          rsp.top_version = top_ver[r.vidx];
        else rsp.status = srst_pkg::ST_NO_DEF;
      end
      srst_pkg::KIND_DEF: begin
        if (int'(r.vidx) < srst_pkg::NUM_VARS) begin
          if (top_valid[r.vidx] && top_blk[r.vidx] == r.blk) begin
            top_ver[r.vidx] = r.ver;
          end else if (undo_fill >= srst_pkg::LOG_DEPTH) begin
            rsp.status = srst_pkg::ST_LOG_FULL;
          end else begin
            undo_var[undo_fill]    = r.vidx;
            undo_blk[undo_fill]    = r.blk;
            undo_pvalid[undo_fill] = top_valid[r.vidx];
            undo_pblk[undo_fill]   = top_blk[r.vidx];
            undo_pver[undo_fill]   = top_ver[r.vidx];
            undo_fill++;
            top_valid[r.vidx] = 1'b1;
            top_blk[r.vidx]   = r.blk;
            top_ver[r.vidx]   = r.ver;
          end
        end
      end
      srst_pkg::KIND_POP: begin
        while (undo_fill > 0 && undo_blk[undo_fill-1] == r.blk) begin
          top_valid[undo_var[undo_fill-1]] = undo_pvalid[undo_fill-1];
          top_blk[undo_var[undo_fill-1]]   = undo_pblk[undo_fill-1];
          top_ver[undo_var[undo_fill-1]]   = undo_pver[undo_fill-1];
          undo_fill--;
          n++;
        end
        rsp.popped = 11'(n);
      end
      default: ;
    endcase
    return rsp;
  endfunction

  function automatic rename_req_t mk_req(logic [1:0] k, int unsigned v, int unsigned b,
                                         int unsigned ver);
    return '{k, 8'(v), 16'(b), 16'(ver)};
  endfunction

  function automatic dir_row_t row(logic [1:0] k, int unsigned v, int unsigned b,
                                   int unsigned ver, logic typed, int unsigned top,
                                   logic [1:0] st, int unsigned cnt);
    return '{mk_req(k, v, b, ver), typed, '{16'(top), st, 11'(cnt)}};
  endfunction

  // offer one item, predict it once taken, then maybe leave a gap
  task automatic send(input rename_req_t r, input logic typed, input rename_rsp_t want);
    rename_rsp_t pred;
    int unsigned gap;
    kind      <= r.kind;
    var_index <= r.vidx;
    block_id  <= r.blk;
    version   <= r.ver;
    in_valid  <= 1'b1;
    do @(posedge clk); while (in_stall);
    n_accepted++;
    pred = rename_predict(r);
    expected_rsp_q.insert(expected_rsp_q.size(), typed ? want : pred);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      if ($urandom_range(0, 3) == 0) burst_left = $urandom_range(40, 150);
      else burst_left = $urandom_range(1, 12);
    end
  endtask

  task automatic send_req(input rename_req_t r);
    send(r, 1'b0, '0);
  endtask

  function automatic int unsigned pick_var();
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, 255);
    return $urandom_range(0, 15);
  endfunction

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_rsp_q.size() == 0) begin
        $error("result item with nothing expected: top_version %0h status %0d popped %0d",
               top_version, status, popped);
        n_errors++;
      end else begin
        rsp_head = expected_rsp_q.pop_front();
        if (top_version !== rsp_head.top_version) begin
          $error("top_version: expected %0h, got %0h", rsp_head.top_version, top_version);
          n_errors++;
        end
        if (status !== rsp_head.status) begin
          $error("status: expected %0d, got %0d", rsp_head.status, status);
          n_errors++;
        end
        if (popped !== rsp_head.popped) begin
          $error("popped: expected %0d, got %0d", rsp_head.popped, popped);
          n_errors++;
        end
      end
    end
  end

  // output back-pressure: changing modes plus one long hold
  int unsigned stall_mode;
  int unsigned mode_left;
  int unsigned hold_left;
  bit          hold_done;

  always @(posedge clk) begin
    if (!hold_done && n_accepted >= 700) begin
      hold_done = 1'b1;
      hold_left = 160;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(8, 80);
      end
      mode_left--;
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= ~out_stall;
      endcase
    end
  end

  initial begin
    #400000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    dir_row_t      dir_tab [25];
    int unsigned   scope_q [$];
    logic [15:0]   fill_blk_q [$];
    int unsigned   perm [256];
    int unsigned   n_sent, act, j, tmp, last_v, pop_blk;
    logic [15:0]   b;

    foreach (top_valid[i]) top_valid[i] = 1'b0;
    undo_fill  = 0;
    n_errors   = 0;
    n_accepted = 0;
    burst_left = 1;
    hold_left  = 0;
    mode_left  = 0;
    hold_done  = 1'b0;

    dir_tab = '{
      row(srst_pkg::KIND_USE, 8'h00, 16'h0000, 16'h0000, 1'b1, 16'h0000, srst_pkg::ST_NO_DEF, 0),
      row(srst_pkg::KIND_USE, 8'hff, 16'hffff, 16'hffff, 1'b1, 16'h0000, srst_pkg::ST_NO_DEF, 0),
      row(srst_pkg::KIND_POP, 8'h00, 16'h0000, 16'h0000, 1'b1, 16'h0000, srst_pkg::ST_OK, 0),
      row(KIND_BAD, 8'hff, 16'hffff, 16'hffff, 1'b1, 16'h0000, srst_pkg::ST_OK, 0),
      row(srst_pkg::KIND_DEF, 8'h00, 16'h0000, 16'h0000, 1'b1, 16'h0000, srst_pkg::ST_OK, 0),
      row(srst_pkg::KIND_DEF, 8'hff, 16'hffff, 16'hffff, 1'b1, 16'h0000, srst_pkg::ST_OK, 0),
      row(srst_pkg::KIND_USE, 8'hff, 16'h0000, 16'h0000, 1'b1, 16'hffff, srst_pkg::ST_OK, 0),
      row(srst_pkg::KIND_USE, 8'h00, 16'hffff, 16'hffff, 1'b1, 16'h0000, srst_pkg::ST_OK, 0),
      row(srst_pkg::KIND_DEF, 8'h00, 16'h0000, 16'h1234, 1'b1, 16'h0000, srst_pkg::ST_OK, 0),
      row(srst_pkg::KIND_USE, 8'h00, 16'h0000, 16'h0000, 1'b0, 0, srst_pkg::ST_OK, 0),
      row(srst_pkg::KIND_DEF, 8'h00, 16'h0001, 16'haaaa, 1'b1, 16'h0000, srst_pkg::ST_OK, 0),
      row(srst_pkg::KIND_DEF, 8'h00, 16'h0002, 16'h5555, 1'b1, 16'h0000, srst_pkg::ST_OK, 0),
      row(srst_pkg::KIND_DEF, 8'hff, 16'h0002, 16'h0001, 1'b1, 16'h0000, srst_pkg::ST_OK, 0),
      row(srst_pkg::KIND_USE, 8'h00, 16'h0000, 16'h0000, 1'b0, 0, srst_pkg::ST_OK, 0),
      row(srst_pkg::KIND_POP, 8'h00, 16'h0002, 16'h0000, 1'b1, 16'h0000, srst_pkg::ST_OK, 2),
      row(srst_pkg::KIND_USE, 8'h00, 16'h0000, 16'h0000, 1'b0, 0, srst_pkg::ST_OK, 0),
      row(srst_pkg::KIND_USE, 8'hff, 16'h0000, 16'h0000, 1'b1, 16'hffff, srst_pkg::ST_OK, 0),
      row(srst_pkg::KIND_POP, 8'h00, 16'h0000, 16'h0000, 1'b1, 16'h0000, srst_pkg::ST_OK, 0),
      row(srst_pkg::KIND_POP, 8'h00, 16'h0001, 16'h0000, 1'b1, 16'h0000, srst_pkg::ST_OK, 1),
      row(srst_pkg::KIND_USE, 8'h00, 16'h0000, 16'h0000, 1'b1, 16'h1234, srst_pkg::ST_OK, 0),
      row(srst_pkg::KIND_POP, 8'h00, 16'hffff, 16'h0000, 1'b1, 16'h0000, srst_pkg::ST_OK, 1),
      row(srst_pkg::KIND_POP, 8'h00, 16'h0000, 16'h0000, 1'b1, 16'h0000, srst_pkg::ST_OK, 1),
      row(srst_pkg::KIND_USE, 8'h00, 16'h0000, 16'h0000, 1'b1, 16'h0000, srst_pkg::ST_NO_DEF, 0),
      row(srst_pkg::KIND_USE, 8'hff, 16'h0000, 16'h0000, 1'b1, 16'h0000, srst_pkg::ST_NO_DEF, 0),
      row(KIND_BAD, 8'h00, 16'h0000, 16'h0000, 1'b1, 16'h0000, srst_pkg::ST_OK, 0)
    };

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_tab[i]) send(dir_tab[i].req, dir_tab[i].typed, dir_tab[i].want);

    // nested scopes as a renaming walk would open and close them
    n_sent = 0;
    while (n_sent < 320) begin
      act = $urandom_range(0, 9);
      if (scope_q.size() == 0 || (act == 0 && scope_q.size() < 8)) begin
        scope_q.insert(scope_q.size(), $urandom_range(0, 65535));
      end else if (act == 1) begin
        pop_blk = scope_q[$];
        scope_q.delete(scope_q.size() - 1);
        send_req(mk_req(srst_pkg::KIND_POP, $urandom_range(0, 255), pop_blk, $urandom));
        n_sent++;
      end else if (act <= 5) begin
        send_req(mk_req(srst_pkg::KIND_DEF, pick_var(), scope_q[$], $urandom));
        n_sent++;
      end else if (act <= 8) begin
        send_req(mk_req(srst_pkg::KIND_USE, pick_var(), $urandom, $urandom));
        n_sent++;
      end else begin
        case ($urandom_range(0, 2))
          0: send_req(mk_req(KIND_BAD, $urandom, $urandom, $urandom));
          1: send_req(mk_req(srst_pkg::KIND_POP, $urandom, $urandom, $urandom));
          default: send_req(mk_req(srst_pkg::KIND_DEF, pick_var(), scope_q[0], $urandom));
        endcase
        n_sent++;
      end
    end
    while (scope_q.size() > 0) begin
      pop_blk = scope_q[$];
      scope_q.delete(scope_q.size() - 1);
      send_req(mk_req(srst_pkg::KIND_POP, $urandom, pop_blk, $urandom));
    end

    // fill the undo log in rounds of one block each
    last_v = 0;
    while (undo_fill < srst_pkg::LOG_DEPTH) begin
      do b = 16'($urandom); while (fill_blk_q.size() > 0 && b == fill_blk_q[$]);
      fill_blk_q.insert(fill_blk_q.size(), b);
      foreach (perm[i]) perm[i] = i;
      for (int i = 255; i > 0; i--) begin
        j = $urandom_range(0, i);
        tmp = perm[i];
        perm[i] = perm[j];
        perm[j] = tmp;
      end
      foreach (perm[i]) begin
        if (undo_fill >= srst_pkg::LOG_DEPTH) break;
        send_req(mk_req(srst_pkg::KIND_DEF, perm[i], b, $urandom));
        last_v = perm[i];
        if ($urandom_range(0, 7) == 0)
          send_req(mk_req(srst_pkg::KIND_USE, $urandom_range(0, 255), $urandom, $urandom));
      end
    end

    // log full: new pushes refused, same-block overwrite still taken
    repeat (4)
      send_req(mk_req(srst_pkg::KIND_DEF, $urandom_range(0, 255), b ^ 16'h8001, $urandom));
    send_req(mk_req(srst_pkg::KIND_DEF, last_v, b, $urandom));
    send_req(mk_req(srst_pkg::KIND_USE, last_v, $urandom, $urandom));
    send_req(mk_req(srst_pkg::KIND_POP, $urandom, b ^ 16'h0001, $urandom));
    while (fill_blk_q.size() > 0) begin
      pop_blk = fill_blk_q[$];
      fill_blk_q.delete(fill_blk_q.size() - 1);
      send_req(mk_req(srst_pkg::KIND_POP, $urandom, pop_blk, $urandom));
      repeat (3)
        send_req(mk_req(srst_pkg::KIND_USE, $urandom_range(0, 255), $urandom, $urandom));
    end
    send_req(mk_req(srst_pkg::KIND_POP, $urandom, $urandom, $urandom));

    in_valid <= 1'b0;
    while (expected_rsp_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (n_errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/srst_pkg.sv
rtl/srst_front.sv
rtl/srst_queue.sv
rtl/srst_back.sv
rtl/ssa_rename_stack_table.sv
test/tb_top.sv
